// ===== src/assert_macros.svh =====
// Shared assertion macros for the aggregation table checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/suat_pkg.sv =====
`default_nettype none

package suat_pkg;

    localparam int KEY_W         = 22;
    localparam int UID_W         = 32;
    localparam int VAL_W         = 32;
    localparam int SUM_W         = 48;
    localparam int CNT_W         = 22;
    localparam int IDX_W         = 6;
    localparam int SLOT_W        = 10;
    localparam int DEFAULT_DEPTH = 64;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PROC  = 2'd1,
        OP_END   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_HIT  = 2'd1,
        ST_NEW  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Query that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [UID_W-1:0]  uid;
        logic [VAL_W-1:0]  cpu;
        logic [VAL_W-1:0]  pages;
        logic [IDX_W-1:0]  idx;
        logic              hit;
        logic              have_free;
        logic [SLOT_W-1:0] slot;
        logic              rd_live;
        logic [KEY_W-1:0]  rd_key;
        logic [UID_W-1:0]  rd_owner;
        logic [SUM_W-1:0]  rd_cpu;
        logic [SUM_W-1:0]  rd_pages;
        logic [CNT_W-1:0]  rd_count;
    } token_t;

    // Write of a newly claimed slot, issued when a query leaves the row.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [UID_W-1:0]  uid;
        logic [VAL_W-1:0]  cpu;
        logic [VAL_W-1:0]  pages;
    } claim_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  slot_used;
        logic              live;
        logic [KEY_W-1:0]  key;
        logic [UID_W-1:0]  owner;
        logic [SUM_W-1:0]  cpu;
        logic [SUM_W-1:0]  pages;
        logic [CNT_W-1:0]  count;
    } result_t;

endpackage

`default_nettype wire

// ===== src/suat_ifs.sv =====
`default_nettype none

interface suat_in_if import suat_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    logic [KEY_W-1:0] session_key;
    logic [UID_W-1:0] owner_uid;
    logic [VAL_W-1:0] cpu_seconds;
    logic [VAL_W-1:0] resident_pages;
    logic [IDX_W-1:0] slot_index;

    modport source (output valid, operation, session_key, owner_uid, cpu_seconds,
                    resident_pages, slot_index, input ready);
    modport sink   (input valid, operation, session_key, owner_uid, cpu_seconds,
                    resident_pages, slot_index, output ready);
endinterface

interface suat_out_if import suat_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [IDX_W-1:0] slot_used;
    logic             entry_live;
    logic [KEY_W-1:0] entry_key;
    logic [UID_W-1:0] entry_owner;
    logic [SUM_W-1:0] total_cpu;
    logic [SUM_W-1:0] total_pages;
    logic [CNT_W-1:0] process_count;

    modport source (output valid, status, slot_used, entry_live, entry_key, entry_owner,
                    total_cpu, total_pages, process_count, input ready);
    modport sink   (input valid, status, slot_used, entry_live, entry_key, entry_owner,
                    total_cpu, total_pages, process_count, output ready);
endinterface

`default_nettype wire

// ===== src/suat_cell.sv =====
`default_nettype none

module suat_cell
    import suat_pkg::*;
#(
    parameter int ID = 0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire token_t tok_in,
    input  wire claim_t claim,
    output token_t      tok_out
);

    logic             valid_reg, valid_next;
    logic             seen_reg, seen_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [UID_W-1:0] owner_reg, owner_next;
    logic [SUM_W-1:0] cpu_reg, cpu_next;
    logic [SUM_W-1:0] pages_reg, pages_next;
    logic [CNT_W-1:0] count_reg, count_next;
    token_t           tok_reg, tok_next;

    logic [SUM_W-1:0] cpu_base, pages_base;
    logic [CNT_W-1:0] count_base;
    logic [SUM_W:0]   cpu_sum, pages_sum;

    // Zero stale sums, then add with saturation
    always_comb
    begin
        cpu_base   = seen_reg ? cpu_reg : '0;
        pages_base = seen_reg ? pages_reg : '0;
        count_base = seen_reg ? count_reg : '0;
        cpu_sum    = {1'b0, cpu_base} + (SUM_W+1)'(tok_in.cpu);
        pages_sum  = {1'b0, pages_base} + (SUM_W+1)'(tok_in.pages);
    end

    // Apply the passing item to this slot and hand it on
    always_comb
    begin
        valid_next = valid_reg;
        seen_next  = seen_reg;
        key_next   = key_reg;
        owner_next = owner_reg;
        cpu_next   = cpu_reg;
        pages_next = pages_reg;
        count_next = count_reg;
        tok_next   = tok_in;

        if (tok_in.valid)
        begin
            unique case (tok_in.op)
                OP_START:
                begin
                    seen_next = 1'b0;
                end
                OP_END:
                begin
                    if (!seen_reg)
                        valid_next = 1'b0;
                end
                OP_READ:
                begin
                    if (32'(tok_in.idx) == ID && valid_reg)
                    begin
                        tok_next.rd_live  = 1'b1;
                        tok_next.rd_key   = key_reg;
                        tok_next.rd_owner = owner_reg;
                        tok_next.rd_cpu   = cpu_reg;
                        tok_next.rd_pages = pages_reg;
                        tok_next.rd_count = count_reg;
                    end
                end
                OP_PROC:
                begin
                    if (!tok_in.hit)
                    begin
                        if (!valid_reg)
                        begin
                            if (!tok_in.have_free)
                            begin
                                tok_next.have_free = 1'b1;
                                tok_next.slot      = SLOT_W'(ID);
                            end
                        end
                        else if (key_reg == tok_in.key)
                        begin
                            tok_next.hit  = 1'b1;
                            tok_next.slot = SLOT_W'(ID);
                            seen_next     = 1'b1;
                            cpu_next      = cpu_sum[SUM_W] ? '1 : cpu_sum[SUM_W-1:0];
                            pages_next    = pages_sum[SUM_W] ? '1 : pages_sum[SUM_W-1:0];
                            count_next    = (count_base == '1) ? count_base
                                                               : count_base + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Fill a claimed slot from the record
        if (claim.en && claim.slot == SLOT_W'(ID))
        begin
            valid_next = 1'b1;
            seen_next  = 1'b1;
            key_next   = claim.key;
            owner_next = claim.uid;
            cpu_next   = SUM_W'(claim.cpu);
            pages_next = SUM_W'(claim.pages);
            count_next = CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            seen_reg  <= seen_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        owner_reg <= owner_next;
        cpu_reg   <= cpu_next;
        pages_reg <= pages_next;
        count_reg <= count_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== src/session_usage_aggregation_table.sv =====
// Session usage aggregation table.
// Items enter on in_ch (valid/ready): operation, session key, uid, CPU
// seconds, resident pages and a slot index. One result leaves on out_ch
// for every item: status, slot and, for a read, the stored entry.
// Each slot lives in its own cell; an item walks the row of TABLE_DEPTH
// cells, one cell per cycle, and every cell applies it to its slot. A
// record that misses claims the lowest free slot when it leaves the row.
// An item passes the launch register, the cells of the row, a holding stage
// and then the output register; one item is in the row at a time.
// in_ch.ready is low while an item is in the row or its result waits for
// the output register. A result held in the output register by a stalled
// receiver does not block the next item; a second finished result waits in
// a holding stage until the output register frees.
// Reset clears every slot's valid and seen marks and empties the row.
`default_nettype none

module session_usage_aggregation_table
    import suat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    suat_in_if.sink   in_ch,
    suat_out_if.source out_ch
);

    token_t  link [TABLE_DEPTH+1];
    token_t  launch_reg, launch_next;
    token_t  last_tok;
    claim_t  claim;
    result_t res;
    logic    busy_reg, busy_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    accept;

    assign in_ch.ready = !busy_reg;
    assign accept      = in_ch.valid && !busy_reg;

    // Launch an accepted item into the row
    always_comb
    begin
        launch_next       = '0;
        launch_next.valid = accept;
        launch_next.op    = op_t'(in_ch.operation);
        launch_next.key   = in_ch.session_key;
        launch_next.uid   = in_ch.owner_uid;
        launch_next.cpu   = in_ch.cpu_seconds;
        launch_next.pages = in_ch.resident_pages;
        launch_next.idx   = in_ch.slot_index;
    end

    assign link[0] = launch_reg;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        suat_cell #(.ID(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[g]),
            .claim   (claim),
            .tok_out (link[g+1])
        );
    end

    assign last_tok = link[TABLE_DEPTH];

    // Claim the lowest free slot on a miss
    always_comb
    begin
        claim.en    = last_tok.valid && last_tok.op == OP_PROC && !last_tok.hit
                      && last_tok.have_free;
        claim.slot  = last_tok.slot;
        claim.key   = last_tok.key;
        claim.uid   = last_tok.uid;
        claim.cpu   = last_tok.cpu;
        claim.pages = last_tok.pages;
    end

    // Form the result of the item leaving the row
    always_comb
    begin
        res        = '0;
        res.status = ST_DONE;
        unique case (last_tok.op)
            OP_PROC:
            begin
                if (last_tok.hit)
                begin
                    res.status    = ST_HIT;
                    res.slot_used = IDX_W'(last_tok.slot);
                end
                else if (last_tok.have_free)
                begin
                    res.status    = ST_NEW;
                    res.slot_used = IDX_W'(last_tok.slot);
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            OP_READ:
            begin
                res.slot_used = last_tok.idx;
                res.live      = last_tok.rd_live;
                res.key       = last_tok.rd_key;
                res.owner     = last_tok.rd_owner;
                res.cpu       = last_tok.rd_cpu;
                res.pages     = last_tok.rd_pages;
                res.count     = last_tok.rd_count;
            end
            default:
            begin
            end
        endcase
    end

    // Hold the result, then advance it to the output register
    always_comb
    begin
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (accept)
            busy_next = 1'b1;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        if (last_tok.valid)
        begin
            pend_valid_next = 1'b1;
            pend_next       = res;
        end
        else if (pend_valid_reg && (!out_valid_reg || out_ch.ready))
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg     <= '0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            launch_reg     <= launch_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_reg.status;
    assign out_ch.slot_used     = out_reg.slot_used;
    assign out_ch.entry_live    = out_reg.live;
    assign out_ch.entry_key     = out_reg.key;
    assign out_ch.entry_owner   = out_reg.owner;
    assign out_ch.total_cpu     = out_reg.cpu;
    assign out_ch.total_pages   = out_reg.pages;
    assign out_ch.process_count = out_reg.count;

endmodule

`default_nettype wire

// ===== src/suat_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module suat_checker
    import suat_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [1:0]       status,
    input wire logic [IDX_W-1:0] slot_used,
    input wire logic             entry_live
);

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `ASSERT_SAME(a_live_is_read, clk, rst_n, out_valid && entry_live, status == ST_DONE, "live not done")
    `ASSERT_SAME(a_full_slot, clk, rst_n, out_valid && status == ST_FULL, slot_used == '0, "full slot")

endmodule

bind session_usage_aggregation_table suat_checker u_suat_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .slot_used  (out_ch.slot_used),
    .entry_live (out_ch.entry_live)
);

`default_nettype wire
